[design/abs_pkg.sv]
// shared types and codes for the alternating bit sender
package abs_pkg;

    // input item kinds
    localparam logic [1:0] FN_MSG  = 2'd0;
    localparam logic [1:0] FN_ACK  = 2'd1;
    localparam logic [1:0] FN_TICK = 2'd2;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_TRAILER = 1'b1;

    localparam logic [15:0] TICKS_RESET = 16'd20;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic        seq;
        logic [15:0] checksum;
        logic        retx;
        logic        last;
    } abs_result_t;

endpackage

[design/alternating_bit_sender_unit.sv]
// alternating bit stop-and-wait sender: control, payload memory and resend sequencer
// a message byte goes into the result queue as it is taken and leaves from its registers
// throughput: one message byte per cycle while the result queue has room; the final
//   byte of a message holds input off while the trailer is pushed; a timeout resend moves
//   one stored byte per cycle while the queue has room, via the memory's single read port
// reset: asynchronous, clears all control state and sets ticks_reg to 20; the payload
//   memory is not cleared and no clearing pass runs, input is taken right after reset
module alternating_bit_sender_unit
    import abs_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  data_byte,
    input  logic [19:0] ack_number,
    input  logic [15:0] ack_sum,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_kind,
    output logic [7:0]  out_byte,
    output logic        out_seq,
    output logic [15:0] out_checksum,
    output logic        is_retransmit,
    output logic        last_of_run,
    // configuration
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int POS_W = $clog2(PAYLOAD_BYTES + 1);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PAYLOAD_BYTES);

    // sequencer states
    localparam logic [1:0] S_RUN    = 2'd0;
    localparam logic [1:0] S_TRAIL  = 2'd1;
    localparam logic [1:0] S_RESEND = 2'd2;

    // control state
    logic [1:0]       state_reg, state_next;
    logic             waiting_reg, waiting_next;
    logic             seq_reg, seq_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             accepting_reg, accepting_next;
    logic [15:0]      sum_reg, sum_next;
    logic [15:0]      saved_sum_reg, saved_sum_next;
    logic [15:0]      countdown_reg, countdown_next;
    logic [15:0]      ticks_reg;
    logic             trail_retx_reg, trail_retx_next;
    // resend read pointer and the read in flight
    logic [POS_W-1:0] rs_cnt_reg, rs_cnt_next;
    logic             rd_pending_reg, rd_pending_next;

    // payload memory, one write and one registered read port
    logic [7:0]       payload_mem [PAYLOAD_BYTES];
    logic [7:0]       rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic             rd_en;

    // message byte path
    logic             accept;
    logic             msg_start;
    logic [POS_W-1:0] pos_eff;
    logic [POS_W-1:0] pos_inc;
    logic [15:0]      sum_base;
    logic [15:0]      sum_new;
    logic             msg_full;
    logic             ack_match;
    logic             push_byte;
    logic             rs_done;

    // result queue side
    logic             push_valid;
    logic             push_ok;
    abs_result_t      push_data;
    abs_result_t      out_data;

    assign in_ready = (state_reg == S_RUN) && push_ok;
    assign accept   = in_valid && in_ready;

    // a new message starts after reset or once the previous message is complete
    assign msg_start = !accepting_reg || (pos_reg >= LAST_POS);
    assign pos_eff   = msg_start ? '0 : pos_reg;
    assign sum_base  = msg_start ? {15'b0, seq_reg} : sum_reg;
    assign sum_new   = sum_base + {8'b0, data_byte};
    assign pos_inc   = pos_eff + POS_W'(1);
    assign msg_full  = (pos_inc == LAST_POS);

    // ack must carry the current sequence bit in both number and checksum
    assign ack_match = waiting_reg && (ack_number == {19'b0, seq_reg})
                       && (ack_sum == {15'b0, seq_reg});

    assign mem_we    = accept && (func == FN_MSG) && !waiting_reg;
    assign mem_waddr = pos_eff[IDX_W-1:0];

    // resend: a read is issued once the previous byte has gone into the queue
    assign push_byte = (state_reg == S_RESEND) && rd_pending_reg && push_ok;
    assign rd_en     = (state_reg == S_RESEND) && (rs_cnt_reg != LAST_POS)
                       && (!rd_pending_reg || push_byte);
    assign rs_done   = (state_reg == S_RESEND) && (rs_cnt_reg == LAST_POS)
                       && (!rd_pending_reg || push_byte);

    always_comb
    begin
        state_next      = state_reg;
        waiting_next    = waiting_reg;
        seq_next        = seq_reg;
        pos_next        = pos_reg;
        accepting_next  = accepting_reg;
        sum_next        = sum_reg;
        saved_sum_next  = saved_sum_reg;
        countdown_next  = countdown_reg;
        trail_retx_next = trail_retx_reg;
        rs_cnt_next     = rs_cnt_reg;
        rd_pending_next = rd_pending_reg;
        push_valid      = 1'b0;
        push_data       = '{kind: KIND_PAYLOAD, data: 8'd0, seq: seq_reg,
                            checksum: 16'd0, retx: 1'b0, last: 1'b0};

        case (state_reg)
            S_RUN:
            begin
                if (accept)
                begin
                    case (func)
                        FN_MSG:
                        begin
                            // bytes are dropped while an ack is outstanding
                            if (!waiting_reg)
                            begin
                                push_valid     = 1'b1;
                                push_data.data = data_byte;
                                push_data.last = !msg_full;
                                if (msg_full)
                                begin
                                    saved_sum_next  = sum_new;
                                    waiting_next    = 1'b1;
                                    accepting_next  = 1'b0;
                                    pos_next        = '0;
                                    countdown_next  = ticks_reg;
                                    trail_retx_next = 1'b0;
                                    state_next      = S_TRAIL;
                                end
                                else
                                begin
                                    accepting_next = 1'b1;
                                    pos_next       = pos_inc;
                                    sum_next       = sum_new;
                                end
                            end
                        end
                        FN_ACK:
                        begin
                            if (ack_match)
                            begin
                                waiting_next   = 1'b0;
                                seq_next       = ~seq_reg;
                                countdown_next = 16'd0;
                            end
                        end
                        FN_TICK:
                        begin
                            if (waiting_reg)
                            begin
                                // zero in the register behaves like one
                                if (countdown_reg <= 16'd1)
                                begin
                                    countdown_next  = ticks_reg;
                                    rs_cnt_next     = '0;
                                    rd_pending_next = 1'b0;
                                    state_next      = S_RESEND;
                                end
                                else
                                begin
                                    countdown_next = countdown_reg - 16'd1;
                                end
                            end
                        end
                        default:
                        begin
                            // unused code, no effect
                        end
                    endcase
                end
            end
            S_TRAIL:
            begin
                push_valid         = 1'b1;
                push_data.kind     = KIND_TRAILER;
                push_data.checksum = saved_sum_reg;
                push_data.retx     = trail_retx_reg;
                push_data.last     = 1'b1;
                if (push_ok)
                begin
                    state_next = S_RUN;
                end
            end
            S_RESEND:
            begin
                push_valid     = rd_pending_reg;
                push_data.data = rd_data_reg;
                push_data.retx = 1'b1;
                if (rd_en)
                begin
                    rs_cnt_next     = rs_cnt_reg + POS_W'(1);
                    rd_pending_next = 1'b1;
                end
                else if (push_byte)
                begin
                    rd_pending_next = 1'b0;
                end
                if (rs_done)
                begin
                    trail_retx_next = 1'b1;
                    state_next      = S_TRAIL;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    // payload memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            payload_mem[mem_waddr] <= data_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= payload_mem[rs_cnt_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_RUN;
            waiting_reg    <= 1'b0;
            seq_reg        <= 1'b0;
            pos_reg        <= '0;
            accepting_reg  <= 1'b0;
            sum_reg        <= 16'd0;
            saved_sum_reg  <= 16'd0;
            countdown_reg  <= 16'd0;
            ticks_reg      <= TICKS_RESET;
            trail_retx_reg <= 1'b0;
            rs_cnt_reg     <= '0;
            rd_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            waiting_reg    <= waiting_next;
            seq_reg        <= seq_next;
            pos_reg        <= pos_next;
            accepting_reg  <= accepting_next;
            sum_reg        <= sum_next;
            saved_sum_reg  <= saved_sum_next;
            countdown_reg  <= countdown_next;
            trail_retx_reg <= trail_retx_next;
            rs_cnt_reg     <= rs_cnt_next;
            rd_pending_reg <= rd_pending_next;
            if (cfg_we)
            begin
                ticks_reg <= cfg_wdata;
            end
        end
    end

    // result queue decouples the core from output stalls
    abs_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ok    (push_ok),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign out_kind      = out_data.kind;
    assign out_byte      = out_data.data;
    assign out_seq       = out_data.seq;
    assign out_checksum  = out_data.checksum;
    assign is_retransmit = out_data.retx;
    assign last_of_run   = out_data.last;

`ifndef SYNTHESIS
    // a resend only runs while an ack is outstanding
    a_resend_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESEND) |-> waiting_reg)
        else $error("resend without outstanding ack");

    // a memory read is only in flight during a resend
    a_pending_resend: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pending_reg |-> (state_reg == S_RESEND))
        else $error("read in flight outside resend");

    // resend pointer never runs past the stored payload
    a_rs_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rs_cnt_reg <= LAST_POS)
        else $error("resend pointer out of range");

    // a matching ack flips the sequence bit and leaves the waiting state
    a_ack_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FN_ACK) && ack_match)
        |=> (seq_reg != $past(seq_reg)) && !waiting_reg)
        else $error("accepted ack did not flip sequence");

    // every trailer closes its run
    a_trailer_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && (push_data.kind == KIND_TRAILER)) |-> push_data.last)
        else $error("trailer not marked last");
`endif

endmodule

[design/abs_out_fifo.sv]
// two entry result queue between the sender core and the output channel
module abs_out_fifo
    import abs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    input  abs_result_t push_data,
    output logic        push_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output abs_result_t out_data
);

    abs_result_t entries_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign push_ok   = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entries_reg[rd_ptr_reg];
    assign push      = push_valid && push_ok;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[bench/abs_frame_checker.sv]
// frame predictor and scoreboard for the alternating bit sender
module abs_frame_checker
    import abs_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  data_byte,
    input  logic [19:0] ack_number,
    input  logic [15:0] ack_sum,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        out_kind,
    input  logic [7:0]  out_byte,
    input  logic        out_seq,
    input  logic [15:0] out_checksum,
    input  logic        is_retransmit,
    input  logic        last_of_run,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output int          bad_frames,
    output int          frames_owed
);

    // shadow copy of the sender
    logic [15:0] ticks_setting;
    logic        waiting;
    logic        seq;
    logic        accepting;
    logic [4:0]  fill_pos;
    logic [7:0]  payload [PAYLOAD_BYTES];
    logic [15:0] run_sum;
    logic [15:0] saved_sum;
    logic [15:0] countdown;

    abs_result_t frames_due [$];
    int          reports;

    task automatic push_frame(input logic kind, input logic [7:0] data, input logic [15:0] sum,
                              input logic retx, input logic last);
        abs_result_t f;
        f.kind     = kind;
        f.data     = data;
        f.seq      = seq;
        f.checksum = sum;
        f.retx     = retx;
        f.last     = last;
        frames_due.push_back(f);
    endtask

    task automatic advance_sender(input logic [1:0] f, input logic [7:0] b,
                                  input logic [19:0] num, input logic [15:0] sum);
        case (f)
            FN_MSG:
            begin
                if (!waiting)
                begin
                    if (!accepting || fill_pos >= PAYLOAD_BYTES)
                    begin
                        accepting = 1'b1;
                        fill_pos  = 5'd0;
                        run_sum   = {15'd0, seq};
                    end
                    payload[fill_pos] = b;
                    run_sum  = run_sum + {8'd0, b};
                    fill_pos = fill_pos + 5'd1;
                    push_frame(KIND_PAYLOAD, b, 16'd0, 1'b0, fill_pos < PAYLOAD_BYTES);
                    if (fill_pos >= PAYLOAD_BYTES)
                    begin
                        saved_sum = run_sum;
                        push_frame(KIND_TRAILER, 8'd0, saved_sum, 1'b0, 1'b1);
                        waiting   = 1'b1;
                        accepting = 1'b0;
                        fill_pos  = 5'd0;
                        countdown = ticks_setting;
                    end
                end
            end
            FN_ACK:
            begin
                if (waiting && num == {19'd0, seq} && {4'd0, sum} == num)
                begin
                    waiting   = 1'b0;
                    seq       = ~seq;
                    countdown = 16'd0;
                end
            end
            FN_TICK:
            begin
                if (waiting)
                begin
                    if (countdown <= 16'd1)
                    begin
                        for (int i = 0; i < PAYLOAD_BYTES; i++)
                            push_frame(KIND_PAYLOAD, payload[i], 16'd0, 1'b1, 1'b0);
                        push_frame(KIND_TRAILER, 8'd0, saved_sum, 1'b1, 1'b1);
                        countdown = ticks_setting;
                    end
                    else
                    begin
                        countdown = countdown - 16'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        abs_result_t want;
        if (!rst_n)
        begin
            ticks_setting = TICKS_RESET;
            waiting       = 1'b0;
            seq           = 1'b0;
            accepting     = 1'b0;
            fill_pos      = 5'd0;
            run_sum       = 16'd0;
            saved_sum     = 16'd0;
            countdown     = 16'd0;
            for (int i = 0; i < PAYLOAD_BYTES; i++)
                payload[i] = 8'd0;
            frames_due.delete();
            frames_owed   = 0;
        end
        else
        begin
            // results only leave after their cause has been written into the result queue, so check before predicting
            if (out_valid && out_ready)
            begin
                if (frames_due.size() == 0)
                begin
                    bad_frames++;
                    if (reports < 10)
                        $display("unexpected frame: kind %0d byte %02h seq %0d sum %04h retx %0d last %0d",
                                 out_kind, out_byte, out_seq, out_checksum, is_retransmit,
                                 last_of_run);
                    reports++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (want.kind !== out_kind || want.data !== out_byte || want.seq !== out_seq ||
                        want.checksum !== out_checksum || want.retx !== is_retransmit ||
                        want.last !== last_of_run)
                    begin
                        bad_frames++;
                        if (reports < 10)
                            $display("frame mismatch: want kind %0d byte %02h seq %0d sum %04h retx %0d last %0d, got kind %0d byte %02h seq %0d sum %04h retx %0d last %0d",
                                     want.kind, want.data, want.seq, want.checksum, want.retx,
                                     want.last, out_kind, out_byte, out_seq, out_checksum,
                                     is_retransmit, last_of_run);
                        reports++;
                    end
                end
            end
            if (cfg_we)
                ticks_setting = cfg_wdata;
            if (in_valid && in_ready)
                advance_sender(func, data_byte, ack_number, ack_sum);
            frames_owed = frames_due.size();
        end
    end

endmodule

[bench/tb_alternating_bit_sender_unit.sv]
// stimulus and verdict for the alternating bit sender
module tb_alternating_bit_sender_unit;
    import abs_pkg::*;

    localparam int PAYLOAD_BYTES = 20;
    localparam int ITEM_TARGET   = 260;
    localparam int PHASES        = 6;
    localparam int CYCLE_LIMIT   = 600000;
    // worst case tail: one full resend burst under output stalls
    localparam int DRAIN_CYCLES  = 2 * PAYLOAD_BYTES + 10;
    // func code the block has no use for
    localparam logic [1:0] FN_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [7:0]  data_byte;
    logic [19:0] ack_number;
    logic [15:0] ack_sum;
    logic        out_valid;
    logic        out_ready;
    logic        out_kind;
    logic [7:0]  out_byte;
    logic        out_seq;
    logic [15:0] out_checksum;
    logic        is_retransmit;
    logic        last_of_run;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    int bad_frames;
    int frames_owed;
    int cycle_count;
    // input transfers that actually move the sender (ignored items are not counted)
    int active_items;

    // light view of the sender's protocol state, only used to shape stimulus
    logic        waiting_now;
    logic        seq_now;
    int          fill;
    logic [15:0] ticks_now;

    // stretch of the run with no idling on either side
    logic calm;
    assign calm = (active_items >= 120) && (active_items < 180);

    alternating_bit_sender_unit #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .data_byte     (data_byte),
        .ack_number    (ack_number),
        .ack_sum       (ack_sum),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_kind      (out_kind),
        .out_byte      (out_byte),
        .out_seq       (out_seq),
        .out_checksum  (out_checksum),
        .is_retransmit (is_retransmit),
        .last_of_run   (last_of_run),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    abs_frame_checker #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_frame_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .data_byte     (data_byte),
        .ack_number    (ack_number),
        .ack_sum       (ack_sum),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_kind      (out_kind),
        .out_byte      (out_byte),
        .out_seq       (out_seq),
        .out_checksum  (out_checksum),
        .is_retransmit (is_retransmit),
        .last_of_run   (last_of_run),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .bad_frames    (bad_frames),
        .frames_owed   (frames_owed)
    );

    // clock, period 10
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver side: holds ready low with a chance of 30 in 100 outside the calm stretch
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= calm || ($urandom_range(0, 99) >= 30);
        end
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // one input transfer: optional idle gap, then hold valid and payload until taken
    task automatic send_item(input logic [1:0] f, input logic [7:0] b,
                             input logic [19:0] num, input logic [15:0] sum);
        while (!calm && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        data_byte  <= b;
        ack_number <= num;
        ack_sum    <= sum;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        // keep the stimulus view in step with what the sender did with this transfer
        case (f)
            FN_MSG:
            begin
                if (!waiting_now)
                begin
                    active_items++;
                    fill++;
                    if (fill >= PAYLOAD_BYTES)
                    begin
                        fill        = 0;
                        waiting_now = 1'b1;
                    end
                end
            end
            FN_ACK:
            begin
                if (waiting_now && num == {19'd0, seq_now} && {4'd0, sum} == num)
                begin
                    active_items++;
                    waiting_now = 1'b0;
                    seq_now     = ~seq_now;
                end
            end
            FN_TICK:
            begin
                if (waiting_now)
                    active_items++;
            end
            default:
            begin
            end
        endcase
    endtask

    // register write once the output side has drained and the block has settled
    task automatic write_ticks(input logic [15:0] value);
        in_valid <= 1'b0;
        @(negedge clk);
        while (frames_owed != 0)
            @(negedge clk);
        // an ack or a plain tick gives no result, so wait for it to land before writing
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        ticks_now = value;
    endtask

    // anything at all, every field random
    task automatic noise_item();
        send_item(2'($urandom_range(0, 3)), 8'($urandom), 20'($urandom), 16'($urandom));
    endtask

    // fill the current message, now and then broken off or salted with noise
    task automatic message_run();
        while (!waiting_now)
        begin
            if ($urandom_range(0, 99) < 6)
                noise_item();
            else if ($urandom_range(0, 99) < 2)
                return;
            else
                send_item(FN_MSG, 8'($urandom), 20'($urandom), 16'($urandom));
        end
    endtask

    // traffic while a packet is outstanding: ticks, dropped bytes, near-miss acks, noise, then usually the matching ack
    task automatic waiting_run();
        int          budget;
        logic [19:0] num;
        logic [15:0] sum;
        if (ticks_now <= 16'd8)
            budget = $urandom_range(0, 2 * ticks_now + 3);
        else
            budget = $urandom_range(0, 4);
        repeat (budget)
        begin
            case ($urandom_range(0, 9))
                0: send_item(FN_MSG, 8'($urandom), 20'($urandom), 16'($urandom));
                1:
                begin
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            // wrong sequence number
                            num    = 20'($urandom);
                            num[0] = ~seq_now;
                            sum    = num[15:0];
                        end
                        1:
                        begin
                            // right number, bad checksum
                            num = {19'd0, seq_now};
                            sum = num[15:0] ^ 16'($urandom_range(1, 65535));
                        end
                        default:
                        begin
                            // upper bits of the number set, checksum matches only low bits
                            num = {4'($urandom_range(1, 15)), 15'd0, seq_now};
                            sum = num[15:0];
                        end
                    endcase
                    send_item(FN_ACK, 8'($urandom), num, sum);
                end
                2: noise_item();
                default: send_item(FN_TICK, 8'($urandom), 20'($urandom), 16'($urandom));
            endcase
        end
        if (waiting_now && $urandom_range(0, 99) < 85)
            send_item(FN_ACK, 8'($urandom), {19'd0, seq_now}, {15'd0, seq_now});
    endtask

    initial
    begin
        logic [15:0] tick_plan [PHASES];
        int          goal;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        func        <= FN_MSG;
        data_byte   <= 8'd0;
        ack_number  <= 20'd0;
        ack_sum     <= 16'd0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= 16'd0;
        waiting_now = 1'b0;
        seq_now     = 1'b0;
        fill        = 0;
        ticks_now   = TICKS_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, timer at one tick so a single tick resends
        write_ticks(16'd1);
        // ignored while idle: tick, ack, unused code
        send_item(FN_TICK, 8'h00, 20'h00000, 16'h0000);
        send_item(FN_ACK, 8'hFF, 20'h00000, 16'h0000);
        send_item(FN_UNUSED, 8'hFF, 20'hFFFFF, 16'hFFFF);
        // one full message with both byte extremes
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            send_item(FN_MSG, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom),
                      20'h00000, 16'h0000);
        // byte while waiting is dropped
        send_item(FN_MSG, 8'hA5, 20'h00000, 16'h0000);
        // rejected acks: wrong number, wrong checksum, number beyond checksum range
        send_item(FN_ACK, 8'h00, {19'd0, ~seq_now}, {15'd0, ~seq_now});
        send_item(FN_ACK, 8'h00, {19'd0, seq_now}, 16'hFFFF);
        send_item(FN_ACK, 8'h00, 20'hFFFFF, 16'hFFFF);
        // timer runs out: stored packet goes out again
        send_item(FN_TICK, 8'h00, 20'h00000, 16'h0000);
        // dropped byte, then the matching ack; later bytes start a fresh message
        send_item(FN_MSG, 8'h5A, 20'h00000, 16'h0000);
        send_item(FN_ACK, 8'h00, {19'd0, seq_now}, {15'd0, seq_now});

        // random part across several timer settings, extremes included
        tick_plan[0] = 16'd0;
        tick_plan[1] = 16'hFFFF;
        tick_plan[2] = 16'd3;
        tick_plan[3] = 16'($urandom_range(2, 8));
        tick_plan[4] = 16'd1;
        tick_plan[5] = TICKS_RESET;
        for (int p = 0; p < PHASES; p++)
        begin
            write_ticks(tick_plan[p]);
            goal = active_items + ITEM_TARGET / PHASES;
            while (active_items < goal)
            begin
                if (waiting_now)
                    waiting_run();
                else if ($urandom_range(0, 99) < 75)
                    message_run();
                else
                    repeat ($urandom_range(1, 3)) noise_item();
            end
        end

        // drain: all results in, then a settle window for anything stray
        in_valid <= 1'b0;
        while (frames_owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (bad_frames == 0 && frames_owed == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
